### rtl/core/msrf_pkg.sv
package msrf_pkg;

    localparam int CHANNELS   = 7;
    localparam int CHAN_W     = 3;
    localparam int DATA_W     = 16;
    localparam int CLIP_W     = 16;
    localparam int REJ_W      = 4;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CLIP_W-1:0] CLIP_RESET   = 16'd2560;  // 20 degC in Q8.7
    localparam logic [REJ_W-1:0]  REJECT_RESET = 4'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_CLIP_LIMIT   = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_REJECT_LIMIT = 8'd1;

    typedef enum logic [1:0] {
        ST_FIRST  = 2'd0,
        ST_WITHIN = 2'd1,
        ST_HELD   = 2'd2,
        ST_FORCED = 2'd3
    } status_t;

    typedef struct packed {
        logic [CHAN_W-1:0]        channel;
        logic signed [DATA_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic [CHAN_W-1:0]        channel;
        logic signed [DATA_W-1:0] filtered;
        status_t                  status;
    } result_t;

    typedef struct packed {
        logic [CLIP_W-1:0] clip_limit;
        logic [REJ_W-1:0]  reject_limit;
    } limits_t;

endpackage

### rtl/core/msrf_ifs.sv
interface msrf_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic [msrf_pkg::CHAN_W-1:0]          channel;
    logic signed [msrf_pkg::DATA_W-1:0]   sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface msrf_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [msrf_pkg::CHAN_W-1:0]          out_channel;
    logic signed [msrf_pkg::DATA_W-1:0]   filtered;
    msrf_pkg::status_t                    status;

    modport source (output valid, output out_channel, output filtered, output status,
                    input ready);
    modport sink   (input valid, input out_channel, input filtered, input status,
                    output ready);
endinterface

interface msrf_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [msrf_pkg::CFG_ADDR_W-1:0]      index;
    logic [msrf_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/msrf_chan_bank.sv
// Per-channel state and the accept/hold/force decision for one item.
module msrf_chan_bank (
    input  logic              clk,
    input  logic              rst_n,
    input  msrf_pkg::item_t   item,
    input  logic              update,
    input  msrf_pkg::limits_t limits,
    output msrf_pkg::result_t result
);

    logic signed [msrf_pkg::DATA_W-1:0] last_value_reg [msrf_pkg::CHANNELS];
    logic [msrf_pkg::REJ_W-1:0]         reject_count_reg [msrf_pkg::CHANNELS];
    logic [msrf_pkg::CHANNELS-1:0]      seen_reg;

    logic                               in_range;
    logic signed [msrf_pkg::DATA_W-1:0] cur_last;
    logic [msrf_pkg::REJ_W-1:0]         cur_count;
    logic                               cur_seen;
    logic signed [msrf_pkg::DATA_W:0]   diff;
    logic [msrf_pkg::DATA_W:0]          mag;
    logic                               in_clip;
    logic signed [msrf_pkg::DATA_W-1:0] last_next;
    logic [msrf_pkg::REJ_W-1:0]         count_next;

    assign in_range  = 32'(item.channel) < msrf_pkg::CHANNELS;
    assign cur_last  = in_range ? last_value_reg[item.channel]   : '0;
    assign cur_count = in_range ? reject_count_reg[item.channel] : '0;
    assign cur_seen  = in_range ? seen_reg[item.channel]         : 1'b0;

    // exact 17-bit difference, magnitude never wraps
    assign diff    = {item.sample[msrf_pkg::DATA_W-1], item.sample}
                   - {cur_last[msrf_pkg::DATA_W-1], cur_last};
    assign mag     = diff[msrf_pkg::DATA_W] ? 17'(-diff) : 17'(diff);
    assign in_clip = mag < {1'b0, limits.clip_limit};

    always_comb
    begin
        result.channel  = item.channel;
        result.filtered = item.sample;
        result.status   = msrf_pkg::ST_FIRST;
        last_next       = item.sample;
        count_next      = '0;
        priority if (!in_range || !cur_seen)
        begin
            result.status = msrf_pkg::ST_FIRST;
        end
        else if (in_clip)
        begin
            result.status = msrf_pkg::ST_WITHIN;
        end
        else if (cur_count < limits.reject_limit)
        begin
            result.status   = msrf_pkg::ST_HELD;
            result.filtered = cur_last;
            last_next       = cur_last;
            count_next      = cur_count + 4'd1;
        end
        else
        begin
            result.status = msrf_pkg::ST_FORCED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < msrf_pkg::CHANNELS; k++)
            begin
                last_value_reg[k]   <= '0;
                reject_count_reg[k] <= '0;
            end
            seen_reg <= '0;
        end
        else if (update && in_range)
        begin
            for (int k = 0; k < msrf_pkg::CHANNELS; k++)
            begin
                if (msrf_pkg::CHAN_W'(k) == item.channel)
                begin
                    last_value_reg[k]   <= last_next;
                    reject_count_reg[k] <= count_next;
                    seen_reg[k]         <= 1'b1;
                end
            end
        end
    end

endmodule

### rtl/core/multichannel_spike_reject_filter.sv
// Datapath: an input transfer loads stage 1, then the result register on advance
//   (input and result register, two stages deep).
// Throughput: one sample per cycle while results.ready holds; the per-channel state
//   read-modify-write lands on advance: same-channel back-to-back needs no stall.
// Reset (rst_n low, async): all channels unseen with value and count zero,
//   clip_limit = 2560 (20 degC), reject_limit = 2, pipeline empty.
module multichannel_spike_reject_filter (
    input  logic                 clk,
    input  logic                 rst_n,
    msrf_cfg_if.sink             cfg,
    msrf_sample_if.sink          samples,
    msrf_result_if.source        results
);

    // configuration registers; writes to unknown indexes are dropped
    msrf_pkg::limits_t limits_reg;

    // stage 1: captured sample
    logic              s1_valid_reg;
    msrf_pkg::item_t   s1_item_reg;

    // stage 2: result register
    logic              res_valid_reg;
    msrf_pkg::result_t res_reg;

    msrf_pkg::result_t res_next;
    logic              advance;
    logic              in_xfer;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.clip_limit   <= msrf_pkg::CLIP_RESET;
            limits_reg.reject_limit <= msrf_pkg::REJECT_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == msrf_pkg::REG_CLIP_LIMIT)
            begin
                limits_reg.clip_limit <= cfg.data[msrf_pkg::CLIP_W-1:0];
            end
            if (cfg.index == msrf_pkg::REG_REJECT_LIMIT)
            begin
                limits_reg.reject_limit <= cfg.data[msrf_pkg::REJ_W-1:0];
            end
        end
    end

    // Stage 1 moves into the result register when that register is empty or
    // being drained this cycle. The channel state updates on the same edge, so
    // the next sample in stage 1 always sees fresh state.
    assign advance       = s1_valid_reg && (!res_valid_reg || results.ready);
    assign samples.ready = !s1_valid_reg || advance;
    assign in_xfer       = samples.valid && samples.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_item_reg.channel <= samples.channel;
            s1_item_reg.sample  <= samples.sample;
        end
    end

    msrf_chan_bank u_bank (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (s1_item_reg),
        .update (advance),
        .limits (limits_reg),
        .result (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign results.valid       = res_valid_reg;
    assign results.out_channel = res_reg.channel;
    assign results.filtered    = res_reg.filtered;
    assign results.status      = res_reg.status;

    // a stalled stage 1 keeps its sample
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("stage 1 lost a sample while stalled");

    // every advance lands in the result register
    a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("advanced sample missing from result register");

    // empty stage 1 never blocks the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> samples.ready)
        else $error("input blocked with stage 1 empty");

    // a held result echoes the channel of the item that produced it
    a_chan_copy: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (res_reg.channel == $past(s1_item_reg.channel)))
        else $error("result channel does not match sample channel");

endmodule
